/* rtl/mpe_pkg.sv */
// Package for the maintenance packet engine.
// Holds shared constants, codes and state types; used by the top level and the checker.
package mpe_pkg;

  localparam int unsigned DefIdBytes    = 8;
  localparam int unsigned DefNumFrames  = 16;
  localparam int unsigned DefFirstFrame = 0;

  localparam logic [7:0] TypePing    = 8'hFE;
  localparam logic [7:0] TypeConfig  = 8'hD0;
  localparam logic [7:0] Wildcard    = 8'hFF;
  localparam logic [7:0] SampleLimit = 8'd8;

  localparam logic KindByte  = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic [1:0] OutEcho  = 2'd0;
  localparam logic [1:0] OutEmpty = 2'd1;
  localparam logic [1:0] OutMask  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_QUERY_RD,
    ST_QUERY_ANS,
    ST_EMIT
  } mpe_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL_ALL,
    OP_FILL_ONE,
    OP_OR_ALL,
    OP_OR_ONE
  } mpe_op_e;

endpackage

/* rtl/mpe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module mpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/maintenance_packet_engine.sv */
// Top level of the maintenance packet engine: packet parser, sequencer and frame-mask table.
// Depends on mpe_pkg and mpe_ram.
//
// The block takes one request at a time. A packet byte is decoded after it is taken and,
// when it gives a result, goes on to the emit state. A config pair then updates the
// frame-mask table: allow-everything writes 0xFF to every entry, a single-entry fill to one,
// and a read and a write step OR a sample bit into one entry, or every entry for a frame
// wildcard. A mask query answers with the entry, or zero for a frame out of range. A result
// leaves through an output register, so a new request is taken while an earlier result
// waits; a result that finds that register still full holds the block until the register
// drains. After reset the table reads as all zero at once; no clearing pass is needed.
module maintenance_packet_engine
  import mpe_pkg::*;
#(
  parameter int unsigned ID_BYTES    = DefIdBytes,
  parameter int unsigned NUM_FRAMES  = DefNumFrames,
  parameter int unsigned FIRST_FRAME = DefFirstFrame
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,   // device_id
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,    // packet_type, data_byte, query_frame
  input  logic        s_tuser_i,    // kind
  input  logic        s_tlast_i,    // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,    // out_byte
  output logic [1:0]  m_tuser_o,    // out_kind
  output logic        m_tlast_o     // out_last
);

  localparam int unsigned IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);

  mpe_state_e state_q, state_d;

  logic [63:0]           id_q;
  logic [7:0]            pos_q, pos_d;
  logic                  match_q, match_d;
  logic [7:0]            held_q, held_d;
  logic                  half_q, half_d;
  logic                  fin_q, fin_d;
  logic [NUM_FRAMES-1:0] valid_q, valid_d;

  logic       it_kind_q;
  logic [7:0] it_type_q, it_data_q, it_qframe_q;
  logic       it_last_q;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            walk_all_q, walk_all_d;
  logic [7:0]      bit_q, bit_d;

  logic [1:0] res_kind_q, res_kind_d;
  logic [7:0] res_byte_q, res_byte_d;
  logic       res_last_q, res_last_d;

  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic            ram_we;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic [7:0]      entry_val;

  logic            accept;
  logic            out_free;
  logic [7:0]      id_byte;
  logic            in_id;
  logic            match_now;
  logic            id_done;
  logic            emit;
  logic [1:0]      emit_kind;
  logic [7:0]      emit_byte;
  logic            emit_last;
  mpe_op_e         op;
  logic [IdxW-1:0] op_idx;
  logic [7:0]      op_bit;
  logic            pair_in_range;
  logic [IdxW-1:0] pair_idx;
  logic            q_in_range;
  logic [IdxW-1:0] q_idx;
  logic            walk_end;

  function automatic logic in_range(input logic [7:0] frame);
    logic [8:0] rel;
    rel = {1'b0, frame} - 9'(FIRST_FRAME);
    return (frame >= 8'(FIRST_FRAME)) && (rel < 9'(NUM_FRAMES));
  endfunction

  function automatic logic [IdxW-1:0] rel_idx(input logic [7:0] frame);
    logic [8:0] rel;
    rel = {1'b0, frame} - 9'(FIRST_FRAME);
    return rel[IdxW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign accept      = s_tvalid_i && s_tready_o;
  assign out_free    = !out_valid_q || m_tready_i;
  assign walk_end    = !walk_all_q || (idx_q == LastIdx);

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  assign entry_val = valid_q[idx_q] ? ram_rdata : 8'h00;

  mpe_ram #(
    .Width (8),
    .Depth (NUM_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Decode of the held request.
  always_comb begin
    id_byte       = 8'(id_q >> {pos_q[2:0], 3'b000});
    in_id         = pos_q < 8'(ID_BYTES);
    match_now     = match_q && (id_byte == it_data_q);
    id_done       = in_id && (pos_q == 8'(ID_BYTES - 1)) && match_now;
    pair_in_range = in_range(it_data_q);
    pair_idx      = rel_idx(it_data_q);
    q_in_range    = in_range(it_qframe_q);
    q_idx         = rel_idx(it_qframe_q);
    emit          = 1'b0;
    emit_kind     = OutEcho;
    emit_byte     = 8'h00;
    emit_last     = 1'b1;
    op            = OP_NONE;
    op_idx        = '0;
    op_bit        = 8'h00;
    if (in_id) begin
      if (id_done && (it_type_q == TypePing) && it_last_q) begin
        emit      = 1'b1;
        emit_kind = OutEmpty;
      end
    end else if (match_q) begin
      if (it_type_q == TypePing) begin
        emit      = 1'b1;
        emit_kind = OutEcho;
        emit_byte = it_data_q;
        emit_last = it_last_q;
      end else if ((it_type_q == TypeConfig) && !fin_q && half_q) begin
        op_bit = 8'(1) << held_q[2:0];
        op_idx = pair_idx;
        if ((held_q == Wildcard) && (it_data_q == Wildcard)) begin
          op = OP_FILL_ALL;
        end else if (held_q == Wildcard) begin
          if (pair_in_range) begin
            op = OP_FILL_ONE;
          end
        end else if (held_q < SampleLimit) begin
          if (it_data_q == Wildcard) begin
            op = OP_OR_ALL;
          end else if (pair_in_range) begin
            op = OP_OR_ONE;
          end
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (it_kind_q == KindQuery) begin
          state_d = q_in_range ? ST_QUERY_RD : ST_EMIT;
        end else if (emit) begin
          state_d = ST_EMIT;
        end else begin
          unique case (op)
            OP_FILL_ALL, OP_FILL_ONE: state_d = ST_FILL;
            OP_OR_ALL, OP_OR_ONE:     state_d = ST_RMW_RD;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (walk_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_RMW_RD:    state_d = ST_RMW_WR;
      ST_RMW_WR:    state_d = walk_end ? ST_IDLE : ST_RMW_RD;
      ST_QUERY_RD:  state_d = ST_QUERY_ANS;
      ST_QUERY_ANS: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and packet state.
  always_comb begin
    pos_d      = pos_q;
    match_d    = match_q;
    held_d     = held_q;
    half_d     = half_q;
    fin_d      = fin_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    walk_all_d = walk_all_q;
    bit_d      = bit_q;
    res_kind_d = res_kind_q;
    res_byte_d = res_byte_q;
    res_last_d = res_last_q;
    ram_we     = 1'b0;
    ram_wdata  = 8'hFF;
    unique case (state_q)
      ST_DECODE: begin
        if (it_kind_q == KindQuery) begin
          idx_d      = q_idx;
          res_kind_d = OutMask;
          res_byte_d = 8'h00;
          res_last_d = 1'b1;
        end else begin
          res_kind_d = emit_kind;
          res_byte_d = emit_byte;
          res_last_d = emit_last;
          bit_d      = op_bit;
          walk_all_d = (op == OP_FILL_ALL) || (op == OP_OR_ALL);
          idx_d      = walk_all_d ? '0 : op_idx;
          if (in_id) begin
            match_d = match_now;
            if (id_done && (it_type_q == TypeConfig)) begin
              valid_d = '0;
              half_d  = 1'b0;
              fin_d   = 1'b0;
            end
          end else if (match_q && (it_type_q == TypeConfig) && !fin_q) begin
            if (!half_q) begin
              held_d = it_data_q;
              half_d = 1'b1;
            end else begin
              half_d = 1'b0;
              if (op == OP_FILL_ALL) begin
                fin_d = 1'b1;
              end
            end
          end
          if (it_last_q) begin
            pos_d   = 8'd0;
            match_d = 1'b1;
            held_d  = 8'd0;
            half_d  = 1'b0;
            fin_d   = 1'b0;
          end else if (pos_q != 8'hFF) begin
            pos_d = pos_q + 8'd1;
          end
        end
      end
      ST_FILL: begin
        ram_we         = 1'b1;
        ram_wdata      = 8'hFF;
        valid_d[idx_q] = 1'b1;
        if (!walk_end) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_RMW_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = entry_val | bit_q;
        valid_d[idx_q] = 1'b1;
        if (!walk_end) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_QUERY_ANS: begin
        res_byte_d = entry_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      id_q        <= 64'd0;
      pos_q       <= 8'd0;
      match_q     <= 1'b1;
      held_q      <= 8'd0;
      half_q      <= 1'b0;
      fin_q       <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      match_q <= match_d;
      held_q  <= held_d;
      half_q  <= half_d;
      fin_q   <= fin_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        id_q <= cfg_data_i;
      end
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_kind_q   <= s_tuser_i;
      it_type_q   <= s_tdata_i[7:0];
      it_data_q   <= s_tdata_i[15:8];
      it_qframe_q <= s_tdata_i[23:16];
      it_last_q   <= s_tlast_i;
    end
    idx_q      <= idx_d;
    walk_all_q <= walk_all_d;
    bit_q      <= bit_d;
    res_kind_q <= res_kind_d;
    res_byte_q <= res_byte_d;
    res_last_q <= res_last_d;
    if ((state_q == ST_EMIT) && out_free) begin
      out_kind_q <= res_kind_q;
      out_byte_q <= res_byte_q;
      out_last_q <= res_last_q;
    end
  end

endmodule

/* rtl/mpe_checker.sv */
// Port-level checks for the maintenance packet engine, bound to the top level.
// Depends on mpe_pkg and maintenance_packet_engine.
module mpe_checker
  import mpe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_o,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o,
  input logic [1:0] m_tuser_o,
  input logic       m_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("second request taken while one is in work");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tuser_o == OutEcho) || (m_tuser_o == OutEmpty) || (m_tuser_o == OutMask))
    else $error("result kind out of range");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && ((m_tuser_o == OutEmpty) || (m_tuser_o == OutMask)) |-> m_tlast_o)
    else $error("single-result reply without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == OutEmpty) |-> (m_tdata_o == 8'h00))
    else $error("empty reply carries data");

endmodule

bind maintenance_packet_engine mpe_checker u_mpe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);
